/* sv/fft_pkg.sv */
// Package: shared types, constants and the match and expiry functions of the flow filter table.
`default_nettype none
package fft_pkg;
  localparam int unsigned RuleSlots   = 16;
  localparam int unsigned ShadowSlots = 16;
  localparam int unsigned RouteMax    = 6;
  localparam int unsigned AddrW       = 32;
  localparam int unsigned HoldW       = 16;
  localparam int unsigned TimeW       = 32;
  localparam int unsigned FlowW       = 3 * AddrW + 3;
  localparam int unsigned EntryW      = FlowW + TimeW;

  typedef enum logic [1:0] {
    KIND_CHECK = 2'd0,
    KIND_ADD   = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_PASS  = 3'd0,
    ST_DROP  = 3'd1,
    ST_ADDED = 3'd2,
    ST_FULL  = 3'd3,
    ST_TICK  = 3'd4
  } status_e;

  typedef enum logic [0:0] {
    CFG_TEMP_HOLD = 1'd0,
    CFG_LONG_HOLD = 1'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_ADD_SH,
    S_TICK_RULE,
    S_TICK_FREE,
    S_TICK_SH,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [AddrW-1:0] src;
    logic [AddrW-1:0] dest;
    logic [2:0]       routes;
    logic [AddrW-1:0] gateway;
  } flow_t;

  typedef struct packed {
    flow_t            flow;
    logic [TimeW-1:0] expiry;
  } entry_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [AddrW-1:0] src_ip;
    logic [AddrW-1:0] dst_ip;
    logic [2:0]       route_count;
    logic [AddrW-1:0] first_hop_addr;
    logic [AddrW-1:0] last_hop_addr;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic       long_hold_used;
    logic       shadow_overflow;
  } rsp_t;

  function automatic logic flow_match(flow_t r, logic [AddrW-1:0] src,
                                      logic [AddrW-1:0] dest, logic [2:0] routes,
                                      logic [AddrW-1:0] last);
    logic m;
    m = 1'b0;
    if (r.routes == 3'd1) begin
      m = (r.dest == dest) && ((src == '0) || (r.src == src));
    end else if (r.routes == 3'd2) begin
      m = (routes != 3'd0) && (last == r.gateway);
    end
    return m;
  endfunction

  function automatic logic reached(logic [TimeW-1:0] now, logic [TimeW-1:0] exp);
    logic [TimeW-1:0] d;
    d = now - exp;
    return ~d[TimeW-1];
  endfunction
endpackage
`default_nettype wire

/* sv/fft_if.sv */
// Interfaces: valid/ready request and result channels.
`default_nettype none
interface fft_req_if;
  logic          valid;
  logic          ready;
  fft_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fft_rsp_if;
  logic          valid;
  logic          ready;
  fft_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* sv/fft_ram.sv */
// Generic single-port-write, single-read RAM with registered read data.
`default_nettype none
module fft_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                                            clk_i,
  input  wire logic                                            we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0]    waddr_i,
  input  wire logic [Width-1:0]                                wdata_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0]    raddr_i,
  output logic      [Width-1:0]                                rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

/* sv/flow_filter_table_with_expiry.sv */
// Top level: flow filter rule table with expiry and shadow table.
// One request at a time. A check reads every rule slot from the rule RAM, one per cycle, and
// an add reads every shadow slot before the result is registered. A tick walks the rule RAM
// moving expired rules into the shadow RAM, then walks the shadow RAM freeing expired entries;
// the rule walk reads each valid rule and acts on its data in a second step. Valid bits sit
// in flip-flops; free slots are found by priority encode over them. The result waits in an
// output register; the next request is taken the cycle after the result is taken.
`default_nettype none
module flow_filter_table_with_expiry #(
  parameter int unsigned RULE_SLOTS   = fft_pkg::RuleSlots,
  parameter int unsigned SHADOW_SLOTS = fft_pkg::ShadowSlots,
  parameter int unsigned ROUTE_MAX    = fft_pkg::RouteMax
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [0:0]               cfg_idx_i,
  input  wire logic [fft_pkg::HoldW-1:0] cfg_data_i,
  fft_req_if.sink                       req,
  fft_rsp_if.source                     rsp
);
  localparam int unsigned RW = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam int unsigned SW = (SHADOW_SLOTS > 1) ? $clog2(SHADOW_SLOTS) : 1;
  localparam logic [RW:0] RLast = (RW+1)'(RULE_SLOTS - 1);
  localparam logic [SW:0] SLast = (SW+1)'(SHADOW_SLOTS - 1);
  localparam logic [2:0] RMax = 3'(ROUTE_MAX);

  fft_pkg::state_e state_q, state_d;
  logic [fft_pkg::HoldW-1:0] temp_q, long_q;
  logic [fft_pkg::TimeW-1:0] now_q, now_d;
  logic [RULE_SLOTS-1:0]   rvalid_q, rvalid_d;
  logic [SHADOW_SLOTS-1:0] svalid_q, svalid_d, fresh_q, fresh_d;
  fft_pkg::req_t req_q;
  fft_pkg::rsp_t rsp_q, rsp_d;
  logic rsp_valid_q, rsp_valid_d;
  logic [RW:0] ridx_q, ridx_d;
  logic [SW:0] sidx_q, sidx_d;
  logic rphase_q, rphase_d;
  logic hit_q, hit_d, ovf_q, ovf_d;

  logic r_we, s_we;
  logic [RW-1:0] r_waddr, r_raddr;
  logic [SW-1:0] s_waddr, s_raddr;
  fft_pkg::entry_t r_wdata, s_wdata, r_rdata, s_rdata;

  fft_ram #(.Width(fft_pkg::EntryW), .Depth(RULE_SLOTS)) u_rule_ram (
    .clk_i, .we_i(r_we), .waddr_i(r_waddr), .wdata_i(r_wdata),
    .raddr_i(r_raddr), .rdata_o(r_rdata)
  );
  fft_ram #(.Width(fft_pkg::EntryW), .Depth(SHADOW_SLOTS)) u_shadow_ram (
    .clk_i, .we_i(s_we), .waddr_i(s_waddr), .wdata_i(s_wdata),
    .raddr_i(s_raddr), .rdata_o(s_rdata)
  );

  logic rfree_any, sfree_any;
  logic [RW-1:0] rfree;
  logic [SW-1:0] sfree;
  always_comb begin
    rfree_any = 1'b0;
    rfree = '0;
    for (int i = RULE_SLOTS - 1; i >= 0; i--) begin
      if (!rvalid_q[i]) begin
        rfree_any = 1'b1;
        rfree = RW'(i);
      end
    end
    sfree_any = 1'b0;
    sfree = '0;
    for (int j = SHADOW_SLOTS - 1; j >= 0; j--) begin
      if (!svalid_q[j]) begin
        sfree_any = 1'b1;
        sfree = SW'(j);
      end
    end
  end

  logic [2:0] fr;
  assign fr = (req_q.route_count > RMax) ? RMax : req_q.route_count;

  assign req.ready  = (state_q == fft_pkg::S_IDLE) && !rsp_valid_q;
  assign rsp.valid  = rsp_valid_q;
  assign rsp.data   = rsp_q;

  // address of the entry whose data arrives this cycle is the previous index
  logic [RW-1:0] rprev;
  logic [SW-1:0] sprev;
  assign rprev = RW'(ridx_q - 1'b1);
  assign sprev = SW'(sidx_q - 1'b1);

  always_comb begin
    state_d = state_q;
    now_d = now_q;
    rvalid_d = rvalid_q;
    svalid_d = svalid_q;
    fresh_d = fresh_q;
    rsp_d = rsp_q;
    rsp_valid_d = rsp_valid_q;
    ridx_d = ridx_q;
    sidx_d = sidx_q;
    rphase_d = rphase_q;
    hit_d = hit_q;
    ovf_d = ovf_q;
    r_we = 1'b0;
    r_waddr = rfree;
    r_wdata = '0;
    r_raddr = ridx_q[RW-1:0];
    s_we = 1'b0;
    s_waddr = sfree;
    s_wdata = '0;
    s_raddr = sidx_q[SW-1:0];
    if (rsp_valid_q && rsp.ready) begin
      rsp_valid_d = 1'b0;
    end
    case (state_q)
      fft_pkg::S_IDLE: begin
        ridx_d = '0;
        sidx_d = '0;
        rphase_d = 1'b0;
        hit_d = 1'b0;
        ovf_d = 1'b0;
        fresh_d = '0;
        if (req.valid && req.ready) begin
          case (req.data.kind)
            fft_pkg::KIND_CHECK: state_d = fft_pkg::S_CHECK;
            fft_pkg::KIND_ADD:   state_d = fft_pkg::S_ADD_SH;
            fft_pkg::KIND_TICK: begin
              now_d = now_q + 1'b1;
              state_d = fft_pkg::S_TICK_RULE;
            end
            default: begin
              rsp_d = '{status: fft_pkg::ST_PASS, default: 1'b0};
              rsp_valid_d = 1'b1;
            end
          endcase
        end
      end
      fft_pkg::S_CHECK: begin
        if (rphase_q && rvalid_q[rprev] &&
            fft_pkg::flow_match(r_rdata.flow, req_q.src_ip, req_q.dst_ip, fr,
                                req_q.last_hop_addr)) begin
          hit_d = 1'b1;
        end
        rphase_d = 1'b1;
        if (ridx_q == RLast + 1'b1) begin
          state_d = fft_pkg::S_OUT;
        end else begin
          ridx_d = ridx_q + 1'b1;
        end
      end
      fft_pkg::S_ADD_SH: begin
        if (sidx_q != '0 && svalid_q[sprev] &&
            fft_pkg::flow_match(s_rdata.flow, req_q.src_ip, req_q.dst_ip,
                                req_q.route_count, req_q.last_hop_addr)) begin
          hit_d = 1'b1;
        end
        if (sidx_q == SLast + 1'b1) begin
          state_d = fft_pkg::S_OUT;
        end else begin
          sidx_d = sidx_q + 1'b1;
        end
      end
      fft_pkg::S_TICK_RULE: begin
        // valid rule: read it, then act on its data; empty slots are skipped
        if (!rphase_q) begin
          if (ridx_q == RLast + 1'b1) begin
            sidx_d = '0;
            state_d = fft_pkg::S_TICK_SH;
          end else if (rvalid_q[ridx_q[RW-1:0]]) begin
            rphase_d = 1'b1;
          end else begin
            ridx_d = ridx_q + 1'b1;
          end
        end else begin
          rphase_d = 1'b0;
          r_raddr = ridx_q[RW-1:0];
          if (fft_pkg::reached(now_q, r_rdata.expiry)) begin
            if (sfree_any) begin
              s_we = 1'b1;
              s_wdata.flow = r_rdata.flow;
              s_wdata.expiry = now_q + fft_pkg::TimeW'(long_q);
              svalid_d[sfree] = 1'b1;
              fresh_d[sfree] = 1'b1;
            end else begin
              ovf_d = 1'b1;
            end
            rvalid_d[ridx_q[RW-1:0]] = 1'b0;
          end
          ridx_d = ridx_q + 1'b1;
        end
      end
      fft_pkg::S_TICK_SH: begin
        if (sidx_q != '0 && svalid_q[sprev] && !fresh_q[sprev] &&
            fft_pkg::reached(now_q, s_rdata.expiry)) begin
          svalid_d[sprev] = 1'b0;
        end
        if (sidx_q == SLast + 1'b1) begin
          state_d = fft_pkg::S_OUT;
        end else begin
          sidx_d = sidx_q + 1'b1;
        end
      end
      fft_pkg::S_OUT: begin
        state_d = fft_pkg::S_IDLE;
        rsp_valid_d = 1'b1;
        rsp_d = '0;
        case (req_q.kind)
          fft_pkg::KIND_CHECK: rsp_d.status = hit_q ? fft_pkg::ST_DROP : fft_pkg::ST_PASS;
          fft_pkg::KIND_ADD: begin
            if (!rfree_any) begin
              rsp_d.status = fft_pkg::ST_FULL;
            end else begin
              rsp_d.status = fft_pkg::ST_ADDED;
              rsp_d.long_hold_used = hit_q;
              r_we = 1'b1;
              r_wdata.flow.src = req_q.src_ip;
              r_wdata.flow.dest = req_q.dst_ip;
              r_wdata.flow.routes = req_q.route_count;
              r_wdata.flow.gateway = req_q.first_hop_addr;
              r_wdata.expiry = now_q + fft_pkg::TimeW'(hit_q ? long_q : temp_q);
              rvalid_d[rfree] = 1'b1;
            end
          end
          default: begin
            rsp_d.status = fft_pkg::ST_TICK;
            rsp_d.shadow_overflow = ovf_q;
          end
        endcase
      end
      default: state_d = fft_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fft_pkg::S_IDLE;
      temp_q <= fft_pkg::HoldW'(10);
      long_q <= fft_pkg::HoldW'(60);
      now_q <= '0;
      rvalid_q <= '0;
      svalid_q <= '0;
      fresh_q <= '0;
      rsp_valid_q <= 1'b0;
      ridx_q <= '0;
      sidx_q <= '0;
      rphase_q <= 1'b0;
      hit_q <= 1'b0;
      ovf_q <= 1'b0;
    end else begin
      state_q <= state_d;
      now_q <= now_d;
      rvalid_q <= rvalid_d;
      svalid_q <= svalid_d;
      fresh_q <= fresh_d;
      rsp_valid_q <= rsp_valid_d;
      ridx_q <= ridx_d;
      sidx_q <= sidx_d;
      rphase_q <= rphase_d;
      hit_q <= hit_d;
      ovf_q <= ovf_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          fft_pkg::CFG_TEMP_HOLD: temp_q <= cfg_data_i;
          fft_pkg::CFG_LONG_HOLD: long_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
    if (req.valid && req.ready) begin
      req_q <= req.data;
    end
  end
endmodule
`default_nettype wire

/* sv/fft_checker.sv */
// Checker: port-level assertions for the flow filter table, bound to the top level.
`default_nettype none
module fft_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          req_valid,
  input wire logic          req_ready,
  input wire logic          rsp_valid,
  input wire logic          rsp_ready,
  input wire fft_pkg::rsp_t rsp_data
);
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("result changed while stalled");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> !req_ready)
    else $error("request taken while result pending");
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> rsp_data.status <= fft_pkg::ST_TICK)
    else $error("bad status");
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && rsp_data.long_hold_used |-> rsp_data.status == fft_pkg::ST_ADDED)
    else $error("long hold flag without add");
  a_one_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid && req_ready |=> !req_ready)
    else $error("second request taken at once");
endmodule

bind flow_filter_table_with_expiry fft_checker u_fft_checker (
  .clk_i, .rst_ni, .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);
`default_nettype wire

/* dv/tb_flow_filter_table_with_expiry.sv */
// Testbench: request/result stimulus with a scoreboard predicting the flow filter table.
`default_nettype none
class fft_scoreboard;
  logic [31:0] now_sec;
  logic [15:0] temp_hold, long_hold;
  bit          rv[16];
  fft_pkg::flow_t rule_flow[16];
  logic [31:0] rule_exp[16];
  bit          sv[16];
  fft_pkg::flow_t sh_flow[16];
  logic [31:0] sh_exp[16];
  fft_pkg::rsp_t expected_q[$];
  int errors;

  function new();
    now_sec = 0; temp_hold = 16'd10; long_hold = 16'd60; errors = 0;
    foreach (rv[i]) begin
      rv[i] = 0;
      sv[i] = 0;
    end
  endfunction

  function bit hits(fft_pkg::flow_t r, logic [31:0] s, logic [31:0] d, logic [2:0] n,
                    logic [31:0] l);
    if (r.routes == 3'd1) return (r.dest == d) && (s == 0 || r.src == s);
    if (r.routes == 3'd2) return (n != 0) && (l == r.gateway);
    return 0;
  endfunction

  function bit expired(logic [31:0] e);
    logic [31:0] df;
    df = now_sec - e;
    return !df[31];
  endfunction

  function void set_reg(fft_pkg::cfg_idx_e idx, logic [15:0] v);
    if (idx == fft_pkg::CFG_TEMP_HOLD) temp_hold = v;
    else long_hold = v;
  endfunction

  function void note_request(fft_pkg::req_t q);
    fft_pkg::rsp_t o;
    int slot, s;
    bit fresh[16];
    logic [15:0] hold;
    o = '0;
    case (q.kind)
      fft_pkg::KIND_CHECK: begin
        o.status = fft_pkg::ST_PASS;
        for (int i = 0; i < 16; i++)
          if (rv[i] && hits(rule_flow[i], q.src_ip, q.dst_ip,
                            q.route_count > 6 ? 3'd6 : q.route_count, q.last_hop_addr))
            o.status = fft_pkg::ST_DROP;
      end
      fft_pkg::KIND_ADD: begin
        slot = -1;
        for (int i = 15; i >= 0; i--) if (!rv[i]) slot = i;
        if (slot < 0) o.status = fft_pkg::ST_FULL;
        else begin
          hold = temp_hold;
          for (int j = 0; j < 16; j++)
            if (sv[j] && hits(sh_flow[j], q.src_ip, q.dst_ip, q.route_count,
                              q.last_hop_addr)) begin
              hold = long_hold;
              o.long_hold_used = 1;
            end
          rv[slot] = 1;
          rule_flow[slot] = '{q.src_ip, q.dst_ip, q.route_count, q.first_hop_addr};
          rule_exp[slot] = now_sec + hold;
          o.status = fft_pkg::ST_ADDED;
        end
      end
      fft_pkg::KIND_TICK: begin
        foreach (fresh[j]) fresh[j] = 0;
        now_sec++;
        for (int i = 0; i < 16; i++) begin
          if (rv[i] && expired(rule_exp[i])) begin
            s = -1;
            for (int j = 15; j >= 0; j--) if (!sv[j]) s = j;
            if (s < 0) o.shadow_overflow = 1;
            else begin
              sv[s] = 1;
              fresh[s] = 1;
              sh_flow[s] = rule_flow[i];
              sh_exp[s] = now_sec + long_hold;
            end
            rv[i] = 0;
          end
        end
        for (int j = 0; j < 16; j++)
          if (sv[j] && !fresh[j] && expired(sh_exp[j])) sv[j] = 0;
        o.status = fft_pkg::ST_TICK;
      end
      default: o.status = fft_pkg::ST_PASS;
    endcase
    expected_q.push_back(o);
  endfunction

  function void check_result(fft_pkg::rsp_t got);
    fft_pkg::rsp_t e;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result %h", $time, got);
      errors++;
      return;
    end
    e = expected_q.pop_front();
    if (got.status !== e.status) begin
      $display("%0t: status exp %0d got %0d", $time, e.status, got.status);
      errors++;
    end
    if (got.long_hold_used !== e.long_hold_used) begin
      $display("%0t: long_hold_used exp %0d got %0d", $time, e.long_hold_used,
               got.long_hold_used);
      errors++;
    end
    if (got.shadow_overflow !== e.shadow_overflow) begin
      $display("%0t: shadow_overflow exp %0d got %0d", $time, e.shadow_overflow,
               got.shadow_overflow);
      errors++;
    end
  endfunction
endclass

module tb_flow_filter_table_with_expiry;
  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we_i = 0;
  logic [0:0] cfg_idx_i = '0;
  logic [fft_pkg::HoldW-1:0] cfg_data_i = '0;
  fft_req_if req ();
  fft_rsp_if rsp ();
  fft_scoreboard flow_sb;
  longint cycles = 0;
  logic [31:0] addr_pool[8];

  flow_filter_table_with_expiry i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .req(req.sink), .rsp(rsp.source)
  );

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  initial begin
    req.valid = 0;
    req.data = '0;
    rsp.ready = 0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("flow_filter_table_with_expiry verification failed");
      $finish;
    end
  end

  // result side with random stalls
  initial begin
    int stall;
    wait (rst_ni);
    forever begin
      stall = $urandom_range(0, 7);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall != 0) begin
        rsp.ready <= 0;
        repeat (stall) @(posedge clk_i);
      end
      rsp.ready <= 1;
      @(posedge clk_i);
      while (!rsp.valid) @(posedge clk_i);
      flow_sb.check_result(rsp.data);
    end
  end

  task automatic send_request(fft_pkg::req_t q, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      req.valid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    req.valid <= 1;
    req.data <= q;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    flow_sb.note_request(q);
  endtask

  task automatic write_reg(fft_pkg::cfg_idx_e idx, logic [15:0] v);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 0;
    flow_sb.set_reg(idx, v);
    @(posedge clk_i);
  endtask

  task automatic drain();
    req.valid <= 0;
    while (flow_sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_addr();
    return ($urandom_range(0, 3) == 0) ? $urandom() : addr_pool[$urandom_range(0, 7)];
  endfunction

  function automatic fft_pkg::req_t rand_req();
    fft_pkg::req_t q;
    int k;
    k = $urandom_range(0, 99);
    q.kind = k < 40 ? fft_pkg::KIND_CHECK : k < 75 ? fft_pkg::KIND_ADD :
             k < 98 ? fft_pkg::KIND_TICK : fft_pkg::KIND_NONE;
    q.src_ip = $urandom_range(0, 2) == 0 ? 32'd0 : pick_addr();
    q.dst_ip = pick_addr();
    q.route_count = $urandom_range(0, 3) == 0 ? 3'($urandom_range(0, 7))
                                              : 3'($urandom_range(1, 2));
    q.first_hop_addr = pick_addr();
    q.last_hop_addr = pick_addr();
    return q;
  endfunction

  function automatic fft_pkg::req_t mk(fft_pkg::kind_e k, logic [31:0] s, logic [31:0] d,
                                       logic [2:0] n, logic [31:0] f, logic [31:0] l);
    fft_pkg::req_t q;
    q = '{k, s, d, n, f, l};
    return q;
  endfunction

  initial begin
    flow_sb = new();
    foreach (addr_pool[i]) addr_pool[i] = $urandom();
    addr_pool[0] = 32'hFFFF_FFFF;
    addr_pool[1] = 32'h0000_0001;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed: reset holds, then a one-second temp hold
    send_request(mk(fft_pkg::KIND_CHECK, 0, 0, 0, 0, 0), 0);
    send_request(mk(fft_pkg::KIND_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd1, 32'hFFFF_FFFF, 0),
                 0);
    send_request(mk(fft_pkg::KIND_CHECK, 0, 32'hFFFF_FFFF, 3'd7, 0, 0), 0);
    send_request(mk(fft_pkg::KIND_CHECK, 32'h1, 32'hFFFF_FFFF, 3'd0, 0, 0), 0);
    send_request(mk(fft_pkg::KIND_ADD, 0, 0, 3'd2, 32'hA5A5_5A5A, 0), 0);
    send_request(mk(fft_pkg::KIND_CHECK, 5, 6, 3'd7, 0, 32'hA5A5_5A5A), 0);
    send_request(mk(fft_pkg::KIND_CHECK, 5, 6, 3'd0, 0, 32'hA5A5_5A5A), 0);
    send_request(mk(fft_pkg::KIND_ADD, 1, 2, 3'd0, 3, 4), 0);
    send_request(mk(fft_pkg::KIND_ADD, 1, 2, 3'd7, 3, 4), 0);
    send_request(mk(fft_pkg::KIND_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7, 32'hFFFF_FFFF,
                    32'hFFFF_FFFF), 0);
    drain();
    write_reg(fft_pkg::CFG_TEMP_HOLD, 16'd1);
    write_reg(fft_pkg::CFG_LONG_HOLD, 16'd2);
    for (int i = 0; i < 18; i++)
      send_request(mk(fft_pkg::KIND_ADD, i, 32'hFFFF_FFFF, 3'd1, i, i), 0);
    send_request(mk(fft_pkg::KIND_TICK, 0, 0, 0, 0, 0), 0);
    for (int i = 0; i < 17; i++)
      send_request(mk(fft_pkg::KIND_ADD, i, 32'hFFFF_FFFF, 3'd1, i, i), i < 3);
    send_request(mk(fft_pkg::KIND_TICK, 0, 0, 0, 0, 0), 0);
    send_request(mk(fft_pkg::KIND_TICK, 0, 0, 0, 0, 0), 0);
    send_request(mk(fft_pkg::KIND_TICK, 0, 0, 0, 0, 0), 0);
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(fft_pkg::CFG_TEMP_HOLD, 16'd65535);
          write_reg(fft_pkg::CFG_LONG_HOLD, 16'd1);
        end
        1: begin
          write_reg(fft_pkg::CFG_TEMP_HOLD, 16'd3);
          write_reg(fft_pkg::CFG_LONG_HOLD, 16'd65535);
        end
        2: begin
          write_reg(fft_pkg::CFG_TEMP_HOLD, 16'd10);
          write_reg(fft_pkg::CFG_LONG_HOLD, 16'd60);
        end
        default: begin
          write_reg(fft_pkg::CFG_TEMP_HOLD, 16'($urandom_range(1, 8)));
          write_reg(fft_pkg::CFG_LONG_HOLD, 16'($urandom_range(1, 12)));
        end
      endcase
      for (int n = 0; n < 185; n++) send_request(rand_req(), 0);
      drain();
    end
    if (flow_sb.errors == 0 && flow_sb.expected_q.size() == 0) begin
      $display("flow_filter_table_with_expiry verification clean");
    end else begin
      $display("flow_filter_table_with_expiry verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* sim.f */
sv/fft_pkg.sv
sv/fft_if.sv
sv/fft_ram.sv
sv/flow_filter_table_with_expiry.sv
sv/fft_checker.sv
dv/tb_flow_filter_table_with_expiry.sv
